FILE: rtl/core/mctw_pkg.sv
// ----------------------------------------------------------------------------
// mctw_pkg: shared definitions of the multi-channel task watchdog
// Widths, command and status codes, the channel table entry and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mctw_pkg;

    // Table size and field widths.
    localparam int CHANNELS   = 64;
    localparam int CH_AW      = $clog2(CHANNELS);
    localparam int TAG_W      = 16;
    localparam int CMD_W      = 3;
    localparam int SLOT_W     = 6;
    localparam int TMO_W      = 8;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int TPS_W      = 14;
    localparam int TICK_W     = 32;
    localparam int LIMIT_W    = TMO_W + TPS_W;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000);

    // Command codes carried in the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_REGISTER   = 3'd0,
        CMD_UNREGISTER = 3'd1,
        CMD_UPDATE     = 3'd2,
        CMD_CHECK      = 3'd3,
        CMD_TICK       = 3'd4
    } t_cmd;

    // Channel modes.
    typedef enum logic [MODE_W-1:0] {
        MODE_RUNNING   = 2'd0,
        MODE_SUSPENDED = 2'd1,
        MODE_EXITED    = 2'd2,
        MODE_DEAD      = 2'd3
    } t_mode;

    // Result status codes carried in the output tuser.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_IGNORED = 2'd2,
        ST_NONE    = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_REG_SCAN,
        S_UPD_WR,
        S_CHK_RD,
        S_CHK_EVAL,
        S_CHK_CMP,
        S_RESP
    } t_state;

    // Kind of table write.
    typedef enum logic [1:0] {
        WR_NONE,
        WR_REG,
        WR_UPD,
        WR_CHK
    } t_wr_op;

    // Source of the reported slot.
    typedef enum logic [1:0] {
        RS_ZERO,
        RS_SLOT,
        RS_CNT
    } t_res_slot;

    // Source of the table read address.
    typedef enum logic {
        ADDR_CNT,
        ADDR_SLOT
    } t_addr_sel;

    // One channel table entry, held in RAM.
    typedef struct packed {
        logic               expired;
        t_mode              mode;
        logic [TMO_W-1:0]   limit_sec;
        logic [TICK_W-1:0]  feed_time;
        logic [TAG_W-1:0]   owner_tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       in_ready;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       ram_rd;
        t_addr_sel  addr_sel;
        t_wr_op     wr_op;
        logic       use_set;
        logic       use_clr;
        logic       tick;
        logic       eval_load;
        logic       res_set;
        t_status    res_status;
        t_res_slot  res_slot;
        logic       res_tag;
        logic       out_load;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic  in_valid;
        t_cmd  cmd;
        logic  slot_used;
        logic  cnt_free;
        logic  cnt_last;
        logic  upd_ok;
        logic  chk_expire;
        logic  out_free;
    } t_dp_stat;

endpackage

FILE: rtl/core/multi_channel_task_watchdog.sv
// ----------------------------------------------------------------------------
// multi_channel_task_watchdog: table of software watchdog channels
// Usage:
//   Commands enter on the s_axis channel, the command code in tuser and the
//   slot, timeout, tag and new mode in tdata. Each command yields exactly one
//   result on the m_axis channel: status in tuser, slot and tag in tdata.
//   ticks_per_second is written through i_cfg_wr_en/i_cfg_wr_data while idle.
// Sequencing:
//   Tick, unregister and unknown commands go from decode to the result
//   state; update reads the entry, then writes it. Register scans the in-use
//   flags one slot per cycle. Check reads one table entry at a time (RAM read,
//   multiply, compare). The sequencer handles one command at a time.
// Reset:
//   All channels are freed, the tick counter is zero and ticks_per_second is
//   1000; the table RAM itself needs no clearing, so commands are taken at
//   once after reset.
// Stall:
//   A result waits in the output register until taken; the next command is
//   accepted meanwhile and runs until its own result is ready to hand over.
// ----------------------------------------------------------------------------
module multi_channel_task_watchdog (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration: ticks per second.
    input  logic                             i_cfg_wr_en,
    input  logic [mctw_pkg::TPS_W-1:0]       i_cfg_wr_data,
    // Command items.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata, from bit 0: slot[5:0], timeout_sec[13:6], tag[29:14],
    // new_mode[31:30].
    input  logic [mctw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: command[2:0].
    input  logic [mctw_pkg::CMD_W-1:0]       s_axis_tuser,
    // Result items.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata, from bit 0: slot_res[5:0], tag_res[21:6], zero fill[23:22].
    output logic [mctw_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // tuser: status[1:0].
    output logic [mctw_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import mctw_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_dp_stat  dp_stat;

    // Command sequencer.
    mctw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (dp_stat),
        .o_cmd   (ctrl_cmd)
    );

    // Table, timer and result datapath.
    mctw_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cmd         (ctrl_cmd),
        .o_stat        (dp_stat)
    );

endmodule

FILE: rtl/core/mctw_ram.sv
// ----------------------------------------------------------------------------
// mctw_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mctw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/mctw_ctrl.sv
// ----------------------------------------------------------------------------
// mctw_ctrl: watchdog command sequencer
// Decodes each accepted item and steps the datapath through the table
// scans, the read-modify-write updates and the hand-over of the result.
// ----------------------------------------------------------------------------
module mctw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mctw_pkg::t_dp_stat   i_stat,
    output mctw_pkg::t_ctrl_cmd  o_cmd
);
    import mctw_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_ctrl_cmd cmd;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.cmd)
                    CMD_REGISTER: begin
                        cmd.cnt_clr = 1'b1;
                        n_state     = S_REG_SCAN;
                    end
                    CMD_UNREGISTER: begin
                        cmd.res_set = 1'b1;
                        if (i_stat.slot_used) begin
                            cmd.use_clr    = 1'b1;
                            cmd.res_status = ST_DONE;
                            cmd.res_slot   = RS_SLOT;
                        end else begin
                            cmd.res_status = ST_IGNORED;
                        end
                        n_state = S_RESP;
                    end
                    CMD_UPDATE: begin
                        // Fetch the entry to see whether it has expired.
                        cmd.ram_rd   = 1'b1;
                        cmd.addr_sel = ADDR_SLOT;
                        n_state      = S_UPD_WR;
                    end
                    CMD_CHECK: begin
                        cmd.cnt_clr = 1'b1;
                        n_state     = S_CHK_RD;
                    end
                    CMD_TICK: begin
                        cmd.tick       = 1'b1;
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_DONE;
                        n_state        = S_RESP;
                    end
                    default: begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_IGNORED;
                        n_state        = S_RESP;
                    end
                endcase
            end
            S_REG_SCAN: begin
                // Claim the lowest free slot, one slot per cycle.
                if (i_stat.cnt_free) begin
                    cmd.use_set    = 1'b1;
                    cmd.wr_op      = WR_REG;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_DONE;
                    cmd.res_slot   = RS_CNT;
                    n_state        = S_RESP;
                end else if (i_stat.cnt_last) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_FULL;
                    n_state        = S_RESP;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_UPD_WR: begin
                cmd.res_set = 1'b1;
                if (i_stat.upd_ok) begin
                    cmd.wr_op      = WR_UPD;
                    cmd.res_status = ST_DONE;
                    cmd.res_slot   = RS_SLOT;
                end else begin
                    cmd.res_status = ST_IGNORED;
                end
                n_state = S_RESP;
            end
            S_CHK_RD: begin
                cmd.ram_rd   = 1'b1;
                cmd.addr_sel = ADDR_CNT;
                n_state      = S_CHK_EVAL;
            end
            S_CHK_EVAL: begin
                cmd.eval_load = 1'b1;
                n_state       = S_CHK_CMP;
            end
            S_CHK_CMP: begin
                // The datapath writes back only a corrected or expired entry.
                cmd.wr_op = WR_CHK;
                if (i_stat.chk_expire) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_DONE;
                    cmd.res_slot   = RS_CNT;
                    cmd.res_tag    = 1'b1;
                    n_state        = S_RESP;
                end else if (i_stat.cnt_last) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_NONE;
                    n_state        = S_RESP;
                end else begin
                    cmd.cnt_inc = 1'b1;
                    n_state     = S_CHK_RD;
                end
            end
            S_RESP: begin
                // Wait until the output register can take the result.
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;

    // Every accepted item produces a result before the next is taken.
    a_decode_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECODE) |=> (r_state != S_IDLE))
        else $error("decode returned to idle without a result");

    // A scan step that ends the scan never advances the counter.
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.cnt_inc && cmd.res_set) |-> 1'b0)
        else $error("scan advanced and finished in the same cycle");

endmodule

FILE: rtl/core/mctw_dp.sv
// ----------------------------------------------------------------------------
// mctw_dp: watchdog datapath
// Holds the channel table RAM, the in-use flags, the tick counter, the
// timeout evaluation registers and the result and output registers.
// ----------------------------------------------------------------------------
module mctw_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mctw_pkg::TPS_W-1:0]          i_cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mctw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic [mctw_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mctw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic [mctw_pkg::STATUS_W-1:0]       m_axis_tuser,
    input  mctw_pkg::t_ctrl_cmd                 i_cmd,
    output mctw_pkg::t_dp_stat                  o_stat
);
    import mctw_pkg::*;

    // Configuration, time and flags.
    logic [TPS_W-1:0]    r_tps;
    logic [TICK_W-1:0]   r_now;
    logic [CHANNELS-1:0] r_in_use;
    logic [CH_AW-1:0]    r_cnt;

    // Fields of the item being worked on.
    logic [CMD_W-1:0]    r_cmd;
    logic [SLOT_W-1:0]   r_slot;
    logic [TMO_W-1:0]    r_tmo;
    logic [TAG_W-1:0]    r_tag;
    t_mode               r_mode;

    // Timeout evaluation.
    logic                r_part;
    logic                r_fix;
    logic [TICK_W-1:0]   r_feed;
    logic [TICK_W-1:0]   r_diff;
    logic [LIMIT_W-1:0]  r_limit;

    // Result and output registers.
    t_status             r_res_status;
    logic [SLOT_W-1:0]   r_res_slot;
    logic [TAG_W-1:0]    r_res_tag;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [TAG_W-1:0]    r_out_tag;

    logic                in_acc;
    logic                slot_ok;
    logic [CH_AW-1:0]    slot_idx;
    logic                expire;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_entry              rd;
    t_entry              wr;
    logic                ram_we;
    logic [CH_AW-1:0]    ram_waddr;
    logic [CH_AW-1:0]    ram_raddr;

    assign in_acc   = s_axis_tvalid && i_cmd.in_ready;
    assign slot_ok  = (32'(r_slot) < CHANNELS);
    assign slot_idx = r_slot[CH_AW-1:0];
    assign rd       = t_entry'(ram_rdata);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (i_cfg_wr_en) begin
            r_tps <= i_cfg_wr_data;
        end
    end

    // Tick counter, wrapping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now <= '0;
        end else if (i_cmd.tick) begin
            r_now <= r_now + TICK_W'(1);
        end
    end

    // In-use flags, cleared at reset; a free slot's RAM contents are never used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
        end else if (i_cmd.use_set) begin
            r_in_use[r_cnt] <= 1'b1;
        end else if (i_cmd.use_clr) begin
            r_in_use[slot_idx] <= 1'b0;
        end
    end

    // Scan counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + CH_AW'(1);
        end
    end

    // Input item capture.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= s_axis_tuser;
            r_slot <= s_axis_tdata[5:0];
            r_tmo  <= s_axis_tdata[13:6];
            r_tag  <= s_axis_tdata[29:14];
            r_mode <= t_mode'(s_axis_tdata[31:30]);
        end
    end

    // First evaluation step: timeout product, idle time and feed correction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_load) begin
            r_part  <= r_in_use[r_cnt] && !rd.expired &&
                       (rd.mode != MODE_SUSPENDED) && (rd.mode != MODE_EXITED);
            r_limit <= LIMIT_W'(rd.limit_sec) * LIMIT_W'(r_tps);
            if (rd.feed_time > r_now) begin
                r_fix  <= 1'b1;
                r_feed <= '0;
                r_diff <= r_now;
            end else begin
                r_fix  <= 1'b0;
                r_feed <= rd.feed_time;
                r_diff <= r_now - rd.feed_time;
            end
        end
    end

    // Second evaluation step: the expiry decision.
    assign expire = r_part && (r_now >= TICK_W'(r_limit)) &&
                    (r_diff > TICK_W'(r_limit));

    // Table write data for each kind of write.
    always_comb begin
        wr        = rd;
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        case (i_cmd.wr_op)
            WR_REG: begin
                ram_we       = 1'b1;
                wr.expired   = 1'b0;
                wr.mode      = MODE_RUNNING;
                wr.limit_sec = r_tmo;
                wr.feed_time = r_now;
                wr.owner_tag = r_tag;
            end
            WR_UPD: begin
                ram_we       = 1'b1;
                ram_waddr    = slot_idx;
                wr.mode      = r_mode;
                wr.feed_time = r_now;
            end
            WR_CHK: begin
                ram_we       = r_part && (r_fix || expire);
                wr.feed_time = r_feed;
                if (expire) begin
                    wr.expired = 1'b1;
                    wr.mode    = MODE_DEAD;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_raddr = (i_cmd.addr_sel == ADDR_SLOT) ? slot_idx : r_cnt;

    // Channel table.
    mctw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ENTRY_W'(wr)),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result register, set when the outcome of an item is known.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            case (i_cmd.res_slot)
                RS_SLOT: r_res_slot <= r_slot;
                RS_CNT:  r_res_slot <= SLOT_W'(r_cnt);
                default: r_res_slot <= '0;
            endcase
            r_res_tag <= i_cmd.res_tag ? rd.owner_tag : '0;
        end
    end

    // Output register towards the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_tag    <= r_res_tag;
        end
    end

    assign s_axis_tready = i_cmd.in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {2'b00, r_out_tag, r_out_slot};

    // Status towards the controller.
    always_comb begin
        o_stat            = '0;
        o_stat.in_valid   = s_axis_tvalid;
        o_stat.cmd        = t_cmd'(r_cmd);
        o_stat.slot_used  = slot_ok && r_in_use[slot_idx];
        o_stat.cnt_free   = !r_in_use[r_cnt];
        o_stat.cnt_last   = (r_cnt == CH_AW'(CHANNELS - 1));
        o_stat.upd_ok     = slot_ok && r_in_use[slot_idx] && !rd.expired;
        o_stat.chk_expire = expire;
        o_stat.out_free   = !r_out_valid || m_axis_tready;
    end

    // Time moves only on a tick command.
    a_now_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.tick |=> $stable(r_now))
        else $error("tick counter changed without a tick command");

    // The in-use flags change only on a claim or a release.
    a_use_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.use_set && !i_cmd.use_clr) |=> $stable(r_in_use))
        else $error("in-use flags changed without a claim or release");

    // A waiting result is never overwritten.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || m_axis_tready))
        else $error("output register loaded while a result was waiting");

endmodule
